[rtl/core/sact_pkg.sv]
// Shared constants and types of the set-associative cache tag store.
// Geometry of the address split, the per-set row layout and the result word.
// No dependencies.
package sact_pkg;

   localparam int ADDR_W     = 32;
   localparam int CACHE_BITS = 16;
   localparam int OFFSET_W   = 6;
   localparam int WAY_W      = 3;
   localparam int SET_W      = CACHE_BITS - OFFSET_W - WAY_W;
   localparam int TAG_W      = ADDR_W - OFFSET_W - SET_W;
   localparam int NUM_WAYS   = 1 << WAY_W;
   localparam int NUM_SETS   = 1 << SET_W;

   localparam logic MODE_LOOKUP = 1'b0;
   localparam logic MODE_FILL   = 1'b1;

   typedef struct packed {
      logic [NUM_WAYS-1:0]            valid;
      logic [NUM_WAYS-1:0][TAG_W-1:0] tag;
   } row_type;

   localparam int ROW_W = $bits(row_type);

   typedef struct packed {
      logic              hit;
      logic [WAY_W-1:0]  way;
      logic              evicted;
      logic              wr_en;
   } update_type;

endpackage

[rtl/core/sact_channels.sv]
// Valid/ready channels of the cache tag store: request word and response word.
// Depends on sact_pkg.
interface sact_req_if;
   import sact_pkg::*;
   logic                valid;
   logic                ready;
   logic                mode;
   logic [ADDR_W-1:0]   address;
   logic [WAY_W-1:0]    victim_way;
   modport source (output valid, output mode, output address, output victim_way,
                   input ready);
   modport sink   (input valid, input mode, input address, input victim_way,
                   output ready);
endinterface

interface sact_rsp_if;
   import sact_pkg::*;
   logic                valid;
   logic                ready;
   logic                hit;
   logic [WAY_W-1:0]    way;
   logic [SET_W-1:0]    set_index;
   logic [OFFSET_W-1:0] byte_offset;
   logic                evicted;
   modport source (output valid, output hit, output way, output set_index,
                   output byte_offset, output evicted, input ready);
   modport sink   (input valid, input hit, input way, input set_index,
                   input byte_offset, input evicted, output ready);
endinterface

[rtl/core/sact_ram.sv]
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No dependencies.
module sact_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/sact_way_logic.sv]
// Way compare and allocation for one set row: hit search on lookup,
// lowest free or victim way on fill, and the updated row. Depends on sact_pkg.
module sact_way_logic (
   input  logic                     mode,
   input  logic [sact_pkg::TAG_W-1:0] tag,
   input  logic [sact_pkg::WAY_W-1:0] victim_way,
   input  sact_pkg::row_type        row,
   output sact_pkg::row_type        new_row,
   output sact_pkg::update_type     upd
);
   import sact_pkg::*;

   logic [NUM_WAYS-1:0] match;
   logic                any_match;
   logic [WAY_W-1:0]    match_way;
   logic                any_free;
   logic [WAY_W-1:0]    free_way;
   logic [WAY_W-1:0]    fill_way;

   always_comb begin
      any_match = 1'b0;
      match_way = '0;
      any_free  = 1'b0;
      free_way  = '0;
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         match[w] = row.valid[w] && (row.tag[w] == tag);
         if (match[w]) begin
            any_match = 1'b1;
            match_way = WAY_W'(w);
         end
         if (!row.valid[w]) begin
            any_free = 1'b1;
            free_way = WAY_W'(w);
         end
      end
   end

   assign fill_way = any_free ? free_way : victim_way;

   always_comb begin
      new_row = row;
      upd     = '0;
      case (mode)
         MODE_LOOKUP: begin
            upd.hit = any_match;
            upd.way = any_match ? match_way : '0;
         end
         MODE_FILL: begin
            upd.way               = fill_way;
            upd.evicted           = !any_free;
            upd.wr_en             = 1'b1;
            new_row.valid[fill_way] = 1'b1;
            new_row.tag[fill_way]   = tag;
         end
         default: begin
            upd = '0;
         end
      endcase
   end

endmodule

[rtl/core/set_assoc_cache_tag_store.sv]
// Tag and valid store of an 8-way, 128-set cache with 64-byte lines.
// Request channel req_if: mode (0 lookup, 1 fill), 32-bit address, victim_way.
// Response channel rsp_if: hit, way, set_index, byte_offset, evicted; one word
// per request, in request order.
// A lookup reports a hit and the lowest valid matching way. A fill takes the
// lowest invalid way of the set, or victim_way when the set is full (evicted).
// Each set is one 160-bit row of a 128-entry RAM with a registered read. A row
// is read at the accept edge, compared in the compare stage and, for a fill,
// written back as the word moves on into the response register, which drives
// rsp_if.valid. Throughput is one word per cycle while the receiver does not
// stall; a fill followed by an access to the same set gets the written row
// forwarded instead of the stale RAM read.
// Reset clears a per-set init flag (128 flops); a set not written since reset
// reads as all ways invalid, so no clearing pass is needed and the block takes
// words right after reset.
// When the receiver stalls, the response register holds, the compare stage holds
// behind it and req_if.ready drops once both are full.
module set_assoc_cache_tag_store (
   input  logic clock,
   input  logic reset,
   sact_req_if.sink   req_if,
   sact_rsp_if.source rsp_if
);
   import sact_pkg::*;

   logic                accept;
   logic [SET_W-1:0]    req_set;
   logic                s1_adv;
   logic                wr_en;

   logic                s1_valid_ff, s1_valid_in;
   logic                s1_mode_ff;
   logic [ADDR_W-1:0]   s1_addr_ff;
   logic [WAY_W-1:0]    s1_victim_ff;
   logic                s1_fwd_ff;
   logic                s1_init_ff;
   logic [NUM_SETS-1:0] row_init_ff;
   row_type             fwd_row_ff;

   logic [TAG_W-1:0]    s1_tag;
   logic [SET_W-1:0]    s1_set;
   logic [OFFSET_W-1:0] s1_offset;
   logic [ROW_W-1:0]    rd_data;
   row_type             cur_row;
   row_type             new_row;
   update_type          upd;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff;
   logic [WAY_W-1:0]    rsp_way_ff;
   logic [SET_W-1:0]    rsp_set_ff;
   logic [OFFSET_W-1:0] rsp_offset_ff;
   logic                rsp_evicted_ff;

   assign req_set   = req_if.address[OFFSET_W +: SET_W];
   assign s1_tag    = s1_addr_ff[OFFSET_W + SET_W +: TAG_W];
   assign s1_set    = s1_addr_ff[OFFSET_W +: SET_W];
   assign s1_offset = s1_addr_ff[OFFSET_W-1:0];

   assign s1_adv       = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || s1_adv;
   assign accept       = req_if.valid && req_if.ready;
   assign wr_en        = s1_adv && upd.wr_en;

   assign s1_valid_in  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_adv ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);

   sact_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NUM_SETS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_set),
      .wr_data (new_row),
      .rd_en   (accept),
      .rd_addr (req_set),
      .rd_data (rd_data)
   );

   always_comb begin
      if (s1_fwd_ff) begin
         cur_row = fwd_row_ff;
      end else if (s1_init_ff) begin
         cur_row = row_type'(rd_data);
      end else begin
         cur_row = '0;
      end
   end

   sact_way_logic u_way_logic (
      .mode       (s1_mode_ff),
      .tag        (s1_tag),
      .victim_way (s1_victim_ff),
      .row        (cur_row),
      .new_row    (new_row),
      .upd        (upd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         row_init_ff  <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            row_init_ff[s1_set] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mode_ff   <= req_if.mode;
         s1_addr_ff   <= req_if.address;
         s1_victim_ff <= req_if.victim_way;
         s1_init_ff   <= row_init_ff[req_set];
         s1_fwd_ff    <= wr_en && (req_set == s1_set);
      end
      if (wr_en) begin
         fwd_row_ff <= new_row;
      end
      if (s1_adv) begin
         rsp_hit_ff     <= upd.hit;
         rsp_way_ff     <= upd.way;
         rsp_set_ff     <= s1_set;
         rsp_offset_ff  <= s1_offset;
         rsp_evicted_ff <= upd.evicted;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.hit         = rsp_hit_ff;
   assign rsp_if.way         = rsp_way_ff;
   assign rsp_if.set_index   = rsp_set_ff;
   assign rsp_if.byte_offset = rsp_offset_ff;
   assign rsp_if.evicted     = rsp_evicted_ff;

endmodule
